// ===== rtl/core/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// shared constants and types of the prefix-code bit decoder
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    localparam int SYM_W     = 8;
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 32;
    localparam int PAD_W     = 3;
    localparam int DELAY_LEN = 7;
    localparam int COUNT_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int LCMP_W    = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_IDX_W = $clog2(GROUP_SIZE);
    localparam int GROUP_COUNT = (SYMBOL_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GSEL_W      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CELL_COUNT  = GROUP_COUNT * GROUP_SIZE;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    typedef struct packed {
        logic [MAX_CODE_LEN-1:0] bits;
        logic [MAX_CODE_LEN-1:0] mask;
        logic [COUNT_W-1:0]      count;
    } t_cmp_bus;

    typedef struct packed {
        logic                   found;
        logic [GROUP_IDX_W-1:0] idx;
    } t_grp_res;

endpackage

// ===== rtl/core/huffman_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_bit_decoder
// prefix-code decoder, one compressed bit per input item
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one table entry. A data item (tuser 1) first
// passes the pad delay; while the delay is filling it gives no result. Any
// other data item goes through accept, compare in all table cells at once,
// priority pick within each group of 16 cells, and final pick and, on a
// match or at full code length, the result. The compare and the group pick
// are registered. The result goes to an output register, so the next item
// is taken while a result waits; a new result waits only when the previous
// one has not yet been taken. The length table is cleared by reset.
module huffman_bit_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hbd_pkg::PAD_W-1:0]          i_cfg_wdata,   // pad_bits
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_symbol, entry_length, entry_code, data_bit, zero fill
    input  logic [hbd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tuser,  // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [hbd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // symbol
    output logic                               m_axis_tuser   // error
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_GROUP,
        ST_DECIDE
    } t_state;

    localparam int MCL = hbd_pkg::MAX_CODE_LEN;

    t_state                           r_state;
    logic [hbd_pkg::PAD_W-1:0]        r_pad;
    logic [hbd_pkg::DELAY_LEN-1:0]    r_delay;
    logic [hbd_pkg::PAD_W-1:0]        r_fill;
    logic [MCL-1:0]                   r_bits;
    logic [MCL-1:0]                   r_mask;
    logic [hbd_pkg::COUNT_W-1:0]      r_count;
    logic                             r_o_valid;
    logic [hbd_pkg::SYM_W-1:0]        r_o_sym;
    logic                             r_o_err;

    logic [hbd_pkg::SYM_W-1:0]        w_in_sym;
    logic [hbd_pkg::LEN_W-1:0]        w_in_len;
    logic [hbd_pkg::CODE_W-1:0]       w_in_code;
    logic                             w_in_bit;
    logic                             w_accept;
    logic                             w_load;
    logic                             w_bit;
    hbd_pkg::t_cmp_bus                w_cmp;
    logic [hbd_pkg::CELL_COUNT-1:0]   w_match;
    hbd_pkg::t_grp_res                w_grp [hbd_pkg::GROUP_COUNT];
    logic                             w_hit;
    logic [hbd_pkg::GSEL_W-1:0]       w_gsel;
    logic [hbd_pkg::GROUP_IDX_W-1:0]  w_lidx;
    logic                             w_full;
    logic                             w_result;
    logic                             w_out_free;
    logic                             w_emit;

    assign w_in_sym  = s_axis_tdata[7:0];
    assign w_in_len  = s_axis_tdata[13:8];
    assign w_in_code = s_axis_tdata[45:14];
    assign w_in_bit  = s_axis_tdata[46];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (s_axis_tuser == hbd_pkg::ACT_LOAD);

    assign w_bit = (r_pad == '0) ? w_in_bit : r_delay[r_pad - 3'd1];

    assign w_cmp.bits  = r_bits;
    assign w_cmp.mask  = r_mask;
    assign w_cmp.count = r_count;

    for (genvar c = 0; c < hbd_pkg::CELL_COUNT; c++) begin : g_cell
        if (c < hbd_pkg::SYMBOL_COUNT) begin : g_used
            hbd_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_wr_en   (w_load && (w_in_sym == hbd_pkg::SYM_W'(c))),
                .i_wr_len  (w_in_len),
                .i_wr_code (w_in_code),
                .i_cmp     (w_cmp),
                .o_match   (w_match[c])
            );
        end else begin : g_unused
            assign w_match[c] = 1'b0;
        end
    end

    for (genvar g = 0; g < hbd_pkg::GROUP_COUNT; g++) begin : g_group
        hbd_group u_group (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_match (w_match[g*hbd_pkg::GROUP_SIZE +: hbd_pkg::GROUP_SIZE]),
            .o_res   (w_grp[g])
        );
    end

    always_comb begin
        w_hit  = 1'b0;
        w_gsel = '0;
        w_lidx = '0;
        for (int g = 0; g < hbd_pkg::GROUP_COUNT; g++) begin
            if (w_grp[g].found) begin
                w_hit  = 1'b1;
                w_gsel = hbd_pkg::GSEL_W'(g);
                w_lidx = w_grp[g].idx;
            end
        end
    end

    assign w_full     = (r_count == hbd_pkg::COUNT_W'(MCL));
    assign w_result   = w_hit || w_full;
    assign w_out_free = !r_o_valid || m_axis_tready;
    assign w_emit     = (r_state == ST_DECIDE) && w_result && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pad     <= '0;
            r_delay   <= '0;
            r_fill    <= '0;
            r_bits    <= '0;
            r_mask    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_o_sym   <= '0;
            r_o_err   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pad <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (s_axis_tuser == hbd_pkg::ACT_DATA)) begin
                        r_delay <= {r_delay[hbd_pkg::DELAY_LEN-2:0], w_in_bit};
                        if (r_fill < r_pad) begin
                            r_fill <= r_fill + 3'd1;
                        end else begin
                            r_bits  <= {r_bits[MCL-2:0], w_bit};
                            r_mask  <= {r_mask[MCL-2:0], 1'b1};
                            r_count <= r_count + 1'b1;
                            r_state <= ST_MATCH;
                        end
                    end
                end
                ST_MATCH: begin
                    r_state <= ST_GROUP;
                end
                ST_GROUP: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (!w_result) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_o_sym   <= w_hit ? hbd_pkg::SYM_W'({w_gsel, w_lidx}) : '0;
                        r_o_err   <= !w_hit;
                        r_bits    <= '0;
                        r_mask    <= '0;
                        r_count   <= '0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_sym;
    assign m_axis_tuser  = r_o_err;

    a_err_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error item carries a nonzero symbol");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hbd_pkg::COUNT_W'(MCL))
        else $error("gathered count beyond maximum code length");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_count == '0) && (r_mask == '0) && m_axis_tvalid)
        else $error("result given without clearing the accumulator");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) == int'(r_count))
        else $error("compare mask out of step with gathered count");

    a_data_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == hbd_pkg::ACT_DATA) && (r_fill >= r_pad))
        |=> (r_state == ST_MATCH))
        else $error("decoded data item did not start a compare");

endmodule

// ===== rtl/core/hbd_cell.sv =====
// ----------------------------------------------------------------------------
// hbd_cell
// one code table entry with its own compare against the gathered bits
// ----------------------------------------------------------------------------
module hbd_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [hbd_pkg::LEN_W-1:0]  i_wr_len,
    input  logic [hbd_pkg::CODE_W-1:0] i_wr_code,
    input  hbd_pkg::t_cmp_bus         i_cmp,
    output logic                      o_match
);

    logic [hbd_pkg::LEN_W-1:0]        r_len;
    logic [hbd_pkg::CODE_W-1:0]       r_code;
    logic                             r_match;
    logic [hbd_pkg::MAX_CODE_LEN-1:0] w_code_ext;
    logic                             n_match;

    assign w_code_ext = hbd_pkg::MAX_CODE_LEN'(r_code);

    assign n_match = (r_len != '0)
        && (hbd_pkg::LCMP_W'(r_len) == hbd_pkg::LCMP_W'(i_cmp.count))
        && ((w_code_ext & i_cmp.mask) == i_cmp.bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
            if (i_wr_en) begin
                r_len <= i_wr_len;
            end
        end
    end

    // code bits are only read once a nonzero length has been written with them
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_code <= i_wr_code;
        end
    end

    assign o_match = r_match;

endmodule

// ===== rtl/core/hbd_group.sv =====
// ----------------------------------------------------------------------------
// hbd_group
// registered priority pick over one group of cells, highest index wins
// ----------------------------------------------------------------------------
module hbd_group (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [hbd_pkg::GROUP_SIZE-1:0]   i_match,
    output hbd_pkg::t_grp_res                o_res
);

    hbd_pkg::t_grp_res r_res;
    hbd_pkg::t_grp_res n_res;

    always_comb begin
        n_res = '0;
        for (int i = 0; i < hbd_pkg::GROUP_SIZE; i++) begin
            if (i_match[i]) begin
                n_res.found = 1'b1;
                n_res.idx   = hbd_pkg::GROUP_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== tb/tb_huffman_bit_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_bit_decoder
// self-checking bench for the prefix-code bit decoder: table loads and
// compressed bits go in as stream items, a bit-true predictor builds the
// expected symbol and error results, and each result item is checked in order
// under random idling on both sides and several pad delay settings
// ----------------------------------------------------------------------------
module tb_huffman_bit_decoder;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_END     = 1280;

    localparam int F_SYM  = 0;
    localparam int F_LEN  = F_SYM + hbd_pkg::SYM_W;
    localparam int F_CODE = F_LEN + hbd_pkg::LEN_W;
    localparam int F_BIT  = F_CODE + hbd_pkg::CODE_W;

    typedef struct packed {
        logic [hbd_pkg::SYM_W-1:0] symbol;
        logic                      err;
    } t_decoded;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [hbd_pkg::PAD_W-1:0]       i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // entry_symbol, entry_length, entry_code, data_bit, zero fill
    logic [hbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;   // action
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;          // symbol
    logic                            m_axis_tuser;          // error

    huffman_bit_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predictor state
    logic [hbd_pkg::CODE_W-1:0]       model_code [hbd_pkg::SYMBOL_COUNT];
    logic [hbd_pkg::LEN_W-1:0]        model_len [hbd_pkg::SYMBOL_COUNT] = '{default: '0};
    logic [hbd_pkg::MAX_CODE_LEN-1:0] model_acc = '0;
    int                               model_count = 0;
    logic [hbd_pkg::DELAY_LEN-1:0]    model_delay = '0;
    int                               model_fill = 0;
    logic [hbd_pkg::PAD_W-1:0]        model_pad = '0;

    t_decoded expected_symbols[$];
    t_decoded seen_front;
    int       mismatch_count = 0;
    int       items_sent = 0;
    int       stuck_cycles = 0;
    int       rx_left = 0;
    bit       rx_free = 1'b0;
    bit       tx_burst = 1'b0;

    // current random prefix code
    logic [hbd_pkg::CODE_W-1:0] leaf_code [64];
    int                         leaf_len [64];
    logic [hbd_pkg::SYM_W-1:0]  leaf_sym [64];
    bit                         leaf_on [64];
    int                         leaf_n = 0;
    logic [hbd_pkg::SYM_W-1:0]  table_syms[$];

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic decode_predict(input logic act,
                                  input logic [hbd_pkg::IN_TDATA_W-1:0] payload);
        logic [hbd_pkg::SYM_W-1:0]  sym;
        logic                       b;
        logic                       dbit;
        logic [hbd_pkg::CODE_W-1:0] mask;
        int                         hit;
        t_decoded                   res;
        if (act == hbd_pkg::ACT_LOAD) begin
            sym = payload[F_SYM +: hbd_pkg::SYM_W];
            model_len[sym] = payload[F_LEN +: hbd_pkg::LEN_W];
            model_code[sym] = payload[F_CODE +: hbd_pkg::CODE_W];
            return;
        end
        b = payload[F_BIT];
        if (model_fill < model_pad) begin
            model_delay = {model_delay[hbd_pkg::DELAY_LEN-2:0], b};
            model_fill++;
            return;
        end
        dbit = (model_pad == 0) ? b : model_delay[model_pad - 1];
        model_delay = {model_delay[hbd_pkg::DELAY_LEN-2:0], b};
        model_acc = {model_acc[hbd_pkg::MAX_CODE_LEN-2:0], dbit};
        model_count++;
        hit = -1;
        for (int i = 0; i < hbd_pkg::SYMBOL_COUNT; i++) begin
            if (model_len[i] != 0 && model_len[i] == model_count) begin
                mask = (model_count >= hbd_pkg::CODE_W) ? '1 :
                       hbd_pkg::CODE_W'((64'd1 << model_count) - 1);
                if ((model_code[i] & mask) == model_acc)
                    hit = i;
            end
        end
        if (hit >= 0) begin
            res.symbol = hbd_pkg::SYM_W'(hit);
            res.err = 1'b0;
            expected_symbols.insert(expected_symbols.size(), res);
            model_acc = '0;
            model_count = 0;
        end else if (model_count >= hbd_pkg::MAX_CODE_LEN) begin
            res.symbol = '0;
            res.err = 1'b1;
            expected_symbols.insert(expected_symbols.size(), res);
            model_acc = '0;
            model_count = 0;
        end
    endtask

    task automatic send_item(input logic act, input logic [hbd_pkg::IN_TDATA_W-1:0] payload);
        int gap;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= payload;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_predict(act, payload);
        items_sent++;
    endtask

    task automatic load_entry(input logic [hbd_pkg::SYM_W-1:0] sym,
                              input logic [hbd_pkg::LEN_W-1:0] len,
                              input logic [hbd_pkg::CODE_W-1:0] code);
        send_item(hbd_pkg::ACT_LOAD, {1'b0, 1'($urandom), code, len, sym});
    endtask

    task automatic send_bit(input logic b);
        send_item(hbd_pkg::ACT_DATA, {1'b0, b, 32'($urandom), 6'($urandom), 8'($urandom)});
    endtask

    task automatic send_code(input logic [hbd_pkg::CODE_W-1:0] code, input int len);
        for (int k = len - 1; k >= 0; k--)
            send_bit(code[k]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pad(input logic [hbd_pkg::PAD_W-1:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        model_pad = val;
        i_cfg_we <= 1'b0;
    endtask

    task automatic clear_table();
        while (table_syms.size() != 0)
            load_entry(table_syms.pop_front(), '0, 32'($urandom));
    endtask

    // grow a prefix tree by splitting leaves; chain mode always deepens one path
    task automatic build_prefix_code(input bit chain, input int n_leaves, input bit sparse);
        int                        pick;
        int                        deep;
        bit                        taken [hbd_pkg::SYMBOL_COUNT];
        logic [hbd_pkg::SYM_W-1:0] s;
        taken = '{default: 1'b0};
        leaf_code[0] = '0;
        leaf_len[0] = 1;
        leaf_code[1] = 1;
        leaf_len[1] = 1;
        leaf_n = 2;
        deep = 1;
        while (leaf_n < n_leaves) begin
            pick = chain ? deep : $urandom_range(0, leaf_n - 1);
            if (leaf_len[pick] < hbd_pkg::MAX_CODE_LEN) begin
                leaf_code[leaf_n] = (leaf_code[pick] << 1) | 1;
                leaf_len[leaf_n] = leaf_len[pick] + 1;
                leaf_code[pick] = leaf_code[pick] << 1;
                leaf_len[pick]++;
                deep = $urandom_range(0, 1) ? pick : leaf_n;
                leaf_n++;
            end
        end
        for (int i = 0; i < leaf_n; i++) begin
            do s = hbd_pkg::SYM_W'($urandom); while (taken[s]);
            taken[s] = 1'b1;
            leaf_sym[i] = s;
            leaf_on[i] = !sparse || ($urandom_range(0, 3) != 0);
        end
        leaf_on[0] = 1'b1;
    endtask

    task automatic load_prefix_code();
        logic [hbd_pkg::CODE_W-1:0] upper;
        clear_table();
        for (int i = 0; i < leaf_n; i++) begin
            if (leaf_on[i]) begin
                // junk above the code length must be ignored
                upper = (leaf_len[i] < hbd_pkg::CODE_W) ? (32'($urandom) << leaf_len[i]) : '0;
                load_entry(leaf_sym[i], hbd_pkg::LEN_W'(leaf_len[i]), leaf_code[i] | upper);
                table_syms.insert(table_syms.size(), leaf_sym[i]);
            end
        end
    endtask

    task automatic stream_symbols(input int until_items);
        int k;
        while (items_sent < until_items) begin
            if ($urandom_range(0, 9) != 0) begin
                k = $urandom_range(0, leaf_n - 1);
                send_code(leaf_code[k], leaf_len[k]);
            end else begin
                repeat ($urandom_range(1, 4)) send_bit(1'($urandom));
            end
        end
    endtask

    // short codes, junk above length, duplicate code, zero and oversize length
    task automatic test_table_match();
        load_entry(8'hFF, 6'd1, 32'hFFFF_FFFE);
        load_entry(8'h00, 6'd2, 32'h0000_0002);
        load_entry(8'h40, 6'd2, 32'hFFFF_FFFE);
        load_entry(8'h10, 6'd0, 32'h0000_0003);
        load_entry(8'h20, 6'd63, 32'hFFFF_FFFF);
        load_entry(8'h30, 6'd3, 32'h0000_0006);
        table_syms = '{8'hFF, 8'h00, 8'h40, 8'h10, 8'h20, 8'h30};
        send_bit(1'b0);
        send_code(32'h2, 2);
        send_code(32'h6, 3);
    endtask

    // deepest delay: seven bits held back before anything decodes
    task automatic test_pad_extremes();
        write_pad(3'd7);
        send_code(32'h2, 3);
        repeat (7) send_bit(1'($urandom));
    endtask

    task automatic test_random_streams();
        int phase;
        phase = 0;
        while (items_sent < RANDOM_END) begin
            tx_burst = (phase % 4 == 1);
            rx_free = (phase % 4 == 3);
            if (phase == 0)
                write_pad(3'd0);
            else if (phase == 1)
                write_pad(3'd7);
            else
                write_pad(hbd_pkg::PAD_W'($urandom_range(0, 7)));
            if (phase % 3 == 2)
                build_prefix_code(1'b1, hbd_pkg::MAX_CODE_LEN + 1, 1'b0);
            else
                build_prefix_code(1'b0, $urandom_range(2, 40), $urandom_range(0, 3) == 0);
            load_prefix_code();
            stream_symbols(items_sent + $urandom_range(90, 170));
            phase++;
        end
        tx_burst = 1'b0;
        rx_free = 1'b0;
    endtask

    // one all-ones code of full length: zero runs overflow, one runs match
    task automatic test_unmatched_streams();
        write_pad(3'd0);
        clear_table();
        load_entry(8'hA5, 6'd32, 32'hFFFF_FFFF);
        table_syms.insert(table_syms.size(), 8'hA5);
        repeat (2 * hbd_pkg::MAX_CODE_LEN) send_bit(1'b0);
        repeat (2 * hbd_pkg::MAX_CODE_LEN) send_bit(1'b1);
    endtask

    always @(posedge i_clk) begin
        if (rx_free) begin
            m_axis_tready <= 1'b1;
            rx_left = 0;
        end else if (rx_left > 0) begin
            rx_left--;
        end else if ($urandom_range(0, 99) < 65) begin
            m_axis_tready <= 1'b1;
            rx_left = $urandom_range(0, 8);
        end else begin
            m_axis_tready <= 1'b0;
            rx_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_symbols.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none, actual symbol %0d error %0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                seen_front = expected_symbols.pop_front();
                if (seen_front.symbol !== m_axis_tdata) begin
                    mismatch_count++;
                    $display("%0t: symbol expected %0d actual %0d",
                             $time, seen_front.symbol, m_axis_tdata);
                end
                if (seen_front.err !== m_axis_tuser) begin
                    mismatch_count++;
                    $display("%0t: error flag expected %0d actual %0d",
                             $time, seen_front.err, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_match();
        test_pad_extremes();
        test_random_streams();
        test_unmatched_streams();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_symbols.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
